>>> rtl/can_alarm_buzzer_sequencer_assert.svh
// assertion macros for the alarm buzzer sequencer checker
`ifndef CAN_ALARM_BUZZER_SEQUENCER_ASSERT_SVH
`define CAN_ALARM_BUZZER_SEQUENCER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CABS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cabs check failed");

// next-cycle implication, disabled during reset
`define CABS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cabs check failed");

`endif

>>> rtl/cabs_pkg.sv
// types, constants and register indexes of the alarm buzzer sequencer
`timescale 1ns / 1ps
package cabs_pkg;

    // default command codes and timer width
    localparam int unsigned DEF_FAST_CODE  = 1;
    localparam int unsigned DEF_SLOW_CODE  = 2;
    localparam int unsigned DEF_STOP_CODE  = 3;
    localparam int unsigned DEF_TIME_WIDTH = 16;

    // field widths
    localparam int unsigned ID_W    = 29;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned MS_W    = 16;
    localparam int unsigned PULSE_W = 8;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned CFG_W   = 29;
    localparam int unsigned IDX_W   = 3;

    // request kinds
    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_SWITCH = 2'd1;
    localparam logic [1:0] KIND_FRAME  = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_ALARM_ID     = 3'd0;
    localparam logic [IDX_W-1:0] REG_ALARM_LENGTH = 3'd1;
    localparam logic [IDX_W-1:0] REG_FAST_ON_MS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAST_OFF_MS  = 3'd3;
    localparam logic [IDX_W-1:0] REG_FAST_PULSES  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SLOW_ON_MS   = 3'd5;
    localparam logic [IDX_W-1:0] REG_SLOW_OFF_MS  = 3'd6;
    localparam logic [IDX_W-1:0] REG_SLOW_PULSES  = 3'd7;

    // register reset values
    localparam logic [ID_W-1:0]    RST_ALARM_ID     = 29'd256;
    localparam logic [LEN_W-1:0]   RST_ALARM_LENGTH = 4'd1;
    localparam logic [MS_W-1:0]    RST_FAST_ON_MS   = 16'd100;
    localparam logic [MS_W-1:0]    RST_FAST_OFF_MS  = 16'd100;
    localparam logic [PULSE_W-1:0] RST_FAST_PULSES  = 8'd10;
    localparam logic [MS_W-1:0]    RST_SLOW_ON_MS   = 16'd500;
    localparam logic [MS_W-1:0]    RST_SLOW_OFF_MS  = 16'd500;
    localparam logic [PULSE_W-1:0] RST_SLOW_PULSES  = 8'd5;

    localparam logic [PULSE_W-1:0] PULSE_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]       kind;
        logic             switch_pressed;
        logic [ID_W-1:0]  frame_id;
        logic [LEN_W-1:0] frame_length;
        logic [7:0]       first_byte;
    } t_in_item;

    typedef struct packed {
        logic buzzer;
        logic green_led;
        logic red_led;
        logic yellow_led;
        logic pattern_running;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]    alarm_id;
        logic [LEN_W-1:0]   alarm_length;
        logic [MS_W-1:0]    fast_on_ms;
        logic [MS_W-1:0]    fast_off_ms;
        logic [PULSE_W-1:0] fast_pulses;
        logic [MS_W-1:0]    slow_on_ms;
        logic [MS_W-1:0]    slow_off_ms;
        logic [PULSE_W-1:0] slow_pulses;
    } t_cfg;

endpackage

>>> rtl/can_alarm_buzzer_sequencer.sv
// top level of the CAN alarm buzzer sequencer
//
//  channel   | valid         | stall         | payload
//  ----------+---------------+---------------+--------------
//  request   | i_in_valid    | o_in_stall    | i_in_item
//  result    | o_out_valid   | i_out_stall   | o_out_item
//  config    | i_cfg_we      | -             | i_cfg_index, i_cfg_data
//
// one request per cycle while the request side does not stall; a taken request
// passes through the input register, then through the single-pass update into
// the result register, from which its result is offered
// one result per request; the request side stalls only while the input register
// is full and the result register holds an untaken result
// synchronous active-low reset; no clearing pass
`timescale 1ns / 1ps
module can_alarm_buzzer_sequencer #(
    parameter int unsigned FAST_CODE  = cabs_pkg::DEF_FAST_CODE,
    parameter int unsigned SLOW_CODE  = cabs_pkg::DEF_SLOW_CODE,
    parameter int unsigned STOP_CODE  = cabs_pkg::DEF_STOP_CODE,
    parameter int unsigned TIME_WIDTH = cabs_pkg::DEF_TIME_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cabs_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cabs_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_we,
    input  logic [cabs_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [cabs_pkg::CFG_W-1:0]  i_cfg_data
);
    import cabs_pkg::*;

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;
    logic      fire;
    logic      in_take;

    // the stored request moves on when the result register is free or drains
    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alarm_id     <= RST_ALARM_ID;
            r_cfg.alarm_length <= RST_ALARM_LENGTH;
            r_cfg.fast_on_ms   <= RST_FAST_ON_MS;
            r_cfg.fast_off_ms  <= RST_FAST_OFF_MS;
            r_cfg.fast_pulses  <= RST_FAST_PULSES;
            r_cfg.slow_on_ms   <= RST_SLOW_ON_MS;
            r_cfg.slow_off_ms  <= RST_SLOW_OFF_MS;
            r_cfg.slow_pulses  <= RST_SLOW_PULSES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ALARM_ID:     r_cfg.alarm_id     <= i_cfg_data[ID_W-1:0];
                REG_ALARM_LENGTH: r_cfg.alarm_length <= i_cfg_data[LEN_W-1:0];
                REG_FAST_ON_MS:   r_cfg.fast_on_ms   <= i_cfg_data[MS_W-1:0];
                REG_FAST_OFF_MS:  r_cfg.fast_off_ms  <= i_cfg_data[MS_W-1:0];
                REG_FAST_PULSES:  r_cfg.fast_pulses  <= i_cfg_data[PULSE_W-1:0];
                REG_SLOW_ON_MS:   r_cfg.slow_on_ms   <= i_cfg_data[MS_W-1:0];
                REG_SLOW_OFF_MS:  r_cfg.slow_off_ms  <= i_cfg_data[MS_W-1:0];
                REG_SLOW_PULSES:  r_cfg.slow_pulses  <= i_cfg_data[PULSE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // state and update logic
    cabs_core #(
        .FAST_CODE  (FAST_CODE),
        .SLOW_CODE  (SLOW_CODE),
        .STOP_CODE  (STOP_CODE),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (n_out_item)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/cabs_core.sv
// sequencer state and the single-pass update for one request
`timescale 1ns / 1ps
module cabs_core #(
    parameter int unsigned FAST_CODE  = cabs_pkg::DEF_FAST_CODE,
    parameter int unsigned SLOW_CODE  = cabs_pkg::DEF_SLOW_CODE,
    parameter int unsigned STOP_CODE  = cabs_pkg::DEF_STOP_CODE,
    parameter int unsigned TIME_WIDTH = cabs_pkg::DEF_TIME_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  cabs_pkg::t_in_item  i_item,
    input  cabs_pkg::t_cfg      i_cfg,
    output cabs_pkg::t_out_item o_result
);
    import cabs_pkg::*;

    localparam logic [CODE_W-1:0] C_FAST = CODE_W'(FAST_CODE);
    localparam logic [CODE_W-1:0] C_SLOW = CODE_W'(SLOW_CODE);
    localparam logic [CODE_W-1:0] C_STOP = CODE_W'(STOP_CODE);

    logic                  r_phase_on, n_phase_on;
    logic                  r_buzzer, n_buzzer;
    logic                  r_sound, n_sound;
    logic                  r_green, n_green;
    logic                  r_red, n_red;
    logic                  r_yellow, n_yellow;
    logic [PULSE_W-1:0]    r_pulse_cnt, n_pulse_cnt;
    logic [TIME_WIDTH-1:0] r_timer, n_timer;
    logic                  r_armed, n_armed;
    logic [TIME_WIDTH-1:0] r_on_ms, n_on_ms;
    logic [TIME_WIDTH-1:0] r_off_ms, n_off_ms;
    logic [PULSE_W-1:0]    r_pulses, n_pulses;

    logic do_step;
    logic do_stop;
    logic match;

    assign match = (i_item.frame_id == i_cfg.alarm_id)
                && (i_item.frame_length == i_cfg.alarm_length);

    // event decode, then the phase step on the updated state
    always_comb begin
        n_phase_on  = r_phase_on;
        n_buzzer    = r_buzzer;
        n_sound     = r_sound;
        n_green     = r_green;
        n_red       = r_red;
        n_yellow    = r_yellow;
        n_pulse_cnt = r_pulse_cnt;
        n_timer     = r_timer;
        n_armed     = r_armed;
        n_on_ms     = r_on_ms;
        n_off_ms    = r_off_ms;
        n_pulses    = r_pulses;
        do_step     = 1'b0;
        do_stop     = 1'b0;

        case (i_item.kind)
            KIND_TICK: begin
                if (r_armed) begin
                    if (r_timer <= TIME_WIDTH'(1)) begin
                        n_timer = '0;
                        n_armed = 1'b0;
                        do_step = 1'b1;
                    end else begin
                        n_timer = r_timer - TIME_WIDTH'(1);
                    end
                end
            end
            KIND_SWITCH: begin
                n_sound  = i_item.switch_pressed;
                n_yellow = i_item.switch_pressed;
            end
            KIND_FRAME: begin
                if (match) begin
                    n_green     = 1'b0;
                    n_red       = 1'b1;
                    n_pulse_cnt = '0;
                    n_phase_on  = 1'b0;
                    if (i_item.first_byte == C_FAST) begin
                        n_on_ms  = TIME_WIDTH'(i_cfg.fast_on_ms);
                        n_off_ms = TIME_WIDTH'(i_cfg.fast_off_ms);
                        n_pulses = i_cfg.fast_pulses;
                        do_step  = 1'b1;
                    end else if (i_item.first_byte == C_SLOW) begin
                        n_on_ms  = TIME_WIDTH'(i_cfg.slow_on_ms);
                        n_off_ms = TIME_WIDTH'(i_cfg.slow_off_ms);
                        n_pulses = i_cfg.slow_pulses;
                        do_step  = 1'b1;
                    end else if (i_item.first_byte == C_STOP) begin
                        do_stop = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        // phase step: on phase start or off phase start
        if (do_step) begin
            if (!n_phase_on) begin
                if (n_pulse_cnt != PULSE_MAX) begin
                    n_pulse_cnt = n_pulse_cnt + PULSE_W'(1);
                end
                if (n_pulse_cnt > n_pulses) begin
                    do_stop = 1'b1;
                end else begin
                    if (n_sound) begin
                        n_buzzer = 1'b1;
                    end
                    n_phase_on = 1'b1;
                    n_timer    = n_on_ms;
                    n_armed    = 1'b1;
                end
            end else begin
                n_buzzer   = 1'b0;
                n_phase_on = 1'b0;
                n_timer    = n_off_ms;
                n_armed    = 1'b1;
            end
        end

        // pattern stop returns the leds to idle
        if (do_stop) begin
            n_armed    = 1'b0;
            n_timer    = '0;
            n_green    = 1'b1;
            n_red      = 1'b0;
            n_buzzer   = 1'b0;
            n_phase_on = 1'b0;
        end
    end

    // result fields
    always_comb begin
        o_result.buzzer          = n_buzzer;
        o_result.green_led       = n_green;
        o_result.red_led         = n_red;
        o_result.yellow_led      = n_yellow;
        o_result.pattern_running = n_armed;
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_on  <= 1'b0;
            r_buzzer    <= 1'b0;
            r_sound     <= 1'b0;
            r_green     <= 1'b1;
            r_red       <= 1'b0;
            r_yellow    <= 1'b0;
            r_pulse_cnt <= '0;
            r_timer     <= '0;
            r_armed     <= 1'b0;
            r_on_ms     <= '0;
            r_off_ms    <= '0;
            r_pulses    <= '0;
        end else if (i_fire) begin
            r_phase_on  <= n_phase_on;
            r_buzzer    <= n_buzzer;
            r_sound     <= n_sound;
            r_green     <= n_green;
            r_red       <= n_red;
            r_yellow    <= n_yellow;
            r_pulse_cnt <= n_pulse_cnt;
            r_timer     <= n_timer;
            r_armed     <= n_armed;
            r_on_ms     <= n_on_ms;
            r_off_ms    <= n_off_ms;
            r_pulses    <= n_pulses;
        end
    end

endmodule

>>> rtl/cabs_checker.sv
// port checker for the alarm buzzer sequencer, bound to the top level
`timescale 1ns / 1ps
`include "can_alarm_buzzer_sequencer_assert.svh"
module cabs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cabs_pkg::t_out_item o_out_item
);
    import cabs_pkg::*;

    // a held result stays offered
    `CABS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)

    // a held result keeps its payload
    `CABS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_item))

    // exactly one of the green and red leds is lit
    `CABS_ASSERT_NOW(a_led_excl, i_clk, i_rst_n, o_out_valid, o_out_item.green_led != o_out_item.red_led)

    // the buzzer only sounds inside a running alarm pattern
    `CABS_ASSERT_NOW(a_buzz_alarm, i_clk, i_rst_n, o_out_valid && o_out_item.buzzer, o_out_item.pattern_running && o_out_item.red_led)

endmodule

bind can_alarm_buzzer_sequencer cabs_checker u_cabs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
